>>> hdl/ccslm_pkg.sv
// Shared types and constants of the coil current step-loss monitor.
package ccslm_pkg;

	localparam int SAMPLE_BITS  = 12;
	localparam int NUM_COILS    = 4;
	localparam int MAX_W        = SAMPLE_BITS + 1;
	localparam int CALIB_W      = 14;
	localparam int AVGCNT_W     = 6;
	localparam int LOSS_W       = 8;
	localparam int PC_W         = $clog2(NUM_COILS + 1);
	localparam int ADDR_W       = 5;
	localparam int REG_IDX_W    = 3;
	localparam int DATA_W       = 32;

	// floor(x*11/10) == (x * 11 * 0xCCCD) >> 19 for x*11 below 2^16
	localparam int                  MARGIN_MUL_W = 20;
	localparam logic [MARGIN_MUL_W-1:0] MARGIN_MUL = 20'd576719;
	localparam int                  MARGIN_SHIFT = 19;

	localparam logic [CALIB_W-1:0]     RST_CALIB_SAMPLES = 14'd10000;
	localparam logic [AVGCNT_W-1:0]    RST_AVG_COUNT     = 6'd10;
	localparam logic                   RST_DETECT_EN     = 1'b1;
	localparam logic [LOSS_W-1:0]      RST_LOSS_LIMIT    = 8'd5;
	localparam logic [SAMPLE_BITS-1:0] RST_DELTA_CEILING = 12'd4000;

	localparam logic [REG_IDX_W-1:0] REG_CALIB_SAMPLES = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AVG_COUNT     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DETECT_EN     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LOSS_LIMIT    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DELTA_CEILING = 3'd4;

	typedef enum logic [1:0] {
		PH_CALIB = 2'd0,
		PH_RUN   = 2'd1,
		PH_STOP  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_TALLY,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic eval;
		logic calib;
		logic run;
		logic detect;
		logic avg_end;
		logic margin;
		logic div_step;
	} lane_cmd_t;

	typedef struct packed {
		logic              stop;
		logic [LOSS_W-1:0] total;
	} merge_stat_t;

endpackage

>>> hdl/coil_current_step_loss_monitor_core.sv
// Top level of the coil current step-loss monitor: control sequencer, registers, lanes, result.
// Flow: a transferred item passes EVAL and TALLY, then DIV, where the per-lane dividers run,
//   when it closes an average, and is loaded into the result register from EMIT once that register is free.
// A new item is taken only back in IDLE, so one item is in flight at a time.
// Reset: coil history, maxima, sums and counters clear, phase is calibrating, registers take
//   their reset values; no clearing pass.
module coil_current_step_loss_monitor_core #(
	parameter int MAX_AVG = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ccslm_pkg::SAMPLE_BITS-1:0]   coil_a1_sample,
	input  logic [ccslm_pkg::SAMPLE_BITS-1:0]   coil_a2_sample,
	input  logic [ccslm_pkg::SAMPLE_BITS-1:0]   coil_b1_sample,
	input  logic [ccslm_pkg::SAMPLE_BITS-1:0]   coil_b2_sample,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          phase,
	output logic                                ctrl_valid,
	output logic [ccslm_pkg::SAMPLE_BITS-1:0]   cur_a1,
	output logic [ccslm_pkg::SAMPLE_BITS-1:0]   cur_a2,
	output logic [ccslm_pkg::SAMPLE_BITS-1:0]   cur_b1,
	output logic [ccslm_pkg::SAMPLE_BITS-1:0]   cur_b2,
	output logic [ccslm_pkg::NUM_COILS-1:0]     loss_flags,
	output logic [ccslm_pkg::LOSS_W-1:0]        loss_total,
	output logic                                calib_done,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ccslm_pkg::ADDR_W-1:0]        paddr,
	input  logic [ccslm_pkg::DATA_W-1:0]        pwdata,
	output logic [ccslm_pkg::DATA_W-1:0]        prdata,
	output logic                                pready
);

	localparam int SB    = ccslm_pkg::SAMPLE_BITS;
	localparam int NC    = ccslm_pkg::NUM_COILS;
	localparam int CW    = ccslm_pkg::CALIB_W;
	localparam int N_W   = $clog2(MAX_AVG + 1);
	localparam int SUM_W = SB + $clog2(MAX_AVG);
	localparam int DC_W  = $clog2(SUM_W);
	localparam logic [DC_W-1:0] DIV_LAST = DC_W'(SUM_W - 1);

	// configuration registers
	logic [CW-1:0]                   cfg_calib_q;
	logic [ccslm_pkg::AVGCNT_W-1:0]  cfg_avg_q;
	logic                            cfg_det_q;
	logic [ccslm_pkg::LOSS_W-1:0]    cfg_limit_q;
	logic [SB-1:0]                   cfg_ceil_q;
	logic [ccslm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                            cfg_wr;

	// sequencer and item state
	ccslm_pkg::state_t state_q, state_d;
	ccslm_pkg::phase_t mode_q;
	ccslm_pkg::phase_t item_ph_q;
	logic [CW-1:0]     progress_q;
	logic [N_W-1:0]    fill_q;
	logic              done_q;
	logic              avg_end_q;
	logic [DC_W-1:0]   div_cnt_q;
	logic              emit_load;

	logic [SB-1:0]     sample_s1 [NC];
	logic [SB-1:0]     in_sample [NC];
	logic [SB-1:0]     lane_avg  [NC];
	logic [NC-1:0]     lane_flags;

	logic [N_W-1:0]    avg_n;
	logic [CW-1:0]     target;
	logic [CW-1:0]     prog_inc;
	logic [N_W-1:0]    fill_inc;
	logic              avg_end_c;
	logic              in_xfer;

	ccslm_pkg::lane_cmd_t   lane_cmd;
	ccslm_pkg::merge_stat_t stat;

	// result register
	logic              out_valid_q;
	logic [1:0]        res_phase_q;
	logic              res_ctrl_q;
	logic [SB-1:0]     res_cur_q [NC];
	logic [NC-1:0]     res_flags_q;
	logic [ccslm_pkg::LOSS_W-1:0] res_total_q;
	logic              res_done_q;

	//------------------------------------------------------------------
	// Register port: zero wait states, word addressed
	//------------------------------------------------------------------
	assign reg_idx = paddr[ccslm_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_calib_q <= ccslm_pkg::RST_CALIB_SAMPLES;
			cfg_avg_q   <= ccslm_pkg::RST_AVG_COUNT;
			cfg_det_q   <= ccslm_pkg::RST_DETECT_EN;
			cfg_limit_q <= ccslm_pkg::RST_LOSS_LIMIT;
			cfg_ceil_q  <= ccslm_pkg::RST_DELTA_CEILING;
		end else if (cfg_wr) begin
			case (reg_idx)
				ccslm_pkg::REG_CALIB_SAMPLES: cfg_calib_q <= pwdata[CW-1:0];
				ccslm_pkg::REG_AVG_COUNT:     cfg_avg_q   <= pwdata[ccslm_pkg::AVGCNT_W-1:0];
				ccslm_pkg::REG_DETECT_EN:     cfg_det_q   <= pwdata[0];
				ccslm_pkg::REG_LOSS_LIMIT:    cfg_limit_q <= pwdata[ccslm_pkg::LOSS_W-1:0];
				ccslm_pkg::REG_DELTA_CEILING: cfg_ceil_q  <= pwdata[SB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ccslm_pkg::REG_CALIB_SAMPLES: prdata = ccslm_pkg::DATA_W'(cfg_calib_q);
			ccslm_pkg::REG_AVG_COUNT:     prdata = ccslm_pkg::DATA_W'(cfg_avg_q);
			ccslm_pkg::REG_DETECT_EN:     prdata = ccslm_pkg::DATA_W'(cfg_det_q);
			ccslm_pkg::REG_LOSS_LIMIT:    prdata = ccslm_pkg::DATA_W'(cfg_limit_q);
			ccslm_pkg::REG_DELTA_CEILING: prdata = ccslm_pkg::DATA_W'(cfg_ceil_q);
			default:                      prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Effective counts: calibration length of zero means one sample,
	// average length clamps to 1..MAX_AVG
	//------------------------------------------------------------------
	always_comb begin
		if (cfg_avg_q == '0)
			avg_n = N_W'(1);
		else if (int'(cfg_avg_q) > MAX_AVG)
			avg_n = N_W'(MAX_AVG);
		else
			avg_n = N_W'(cfg_avg_q);
		target    = (cfg_calib_q == '0) ? CW'(1) : cfg_calib_q;
		prog_inc  = progress_q + CW'(1);
		// fill stays below the clamp, so the increment cannot wrap
		fill_inc  = fill_q + N_W'(1);
		avg_end_c = fill_inc >= avg_n;
	end

	assign in_sample[0] = coil_a1_sample;
	assign in_sample[1] = coil_a2_sample;
	assign in_sample[2] = coil_b1_sample;
	assign in_sample[3] = coil_b2_sample;

	assign in_xfer = in_valid & in_ready;

	//------------------------------------------------------------------
	// Sequencer: IDLE takes a transfer, EVAL runs the lanes, TALLY merges
	// loss events and applies the calibration margin, DIV runs the lane
	// dividers when an average closes, EMIT waits for the result register.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ccslm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ccslm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ccslm_pkg::ST_EVAL;
			end
			ccslm_pkg::ST_EVAL: begin
				state_d = ccslm_pkg::ST_TALLY;
			end
			ccslm_pkg::ST_TALLY: begin
				state_d = avg_end_q ? ccslm_pkg::ST_DIV : ccslm_pkg::ST_EMIT;
			end
			ccslm_pkg::ST_DIV: begin
				if (div_cnt_q == DIV_LAST)
					state_d = ccslm_pkg::ST_EMIT;
			end
			ccslm_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_load = 1'b1;
					state_d   = ccslm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ccslm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		lane_cmd.eval     = state_q == ccslm_pkg::ST_EVAL;
		lane_cmd.calib    = item_ph_q == ccslm_pkg::PH_CALIB;
		lane_cmd.run      = item_ph_q == ccslm_pkg::PH_RUN;
		lane_cmd.detect   = cfg_det_q;
		lane_cmd.avg_end  = avg_end_c;
		lane_cmd.margin   = (state_q == ccslm_pkg::ST_TALLY) && done_q;
		lane_cmd.div_step = state_q == ccslm_pkg::ST_DIV;
	end

	// phase, counters and per-item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ccslm_pkg::PH_CALIB;
			item_ph_q  <= ccslm_pkg::PH_CALIB;
			progress_q <= '0;
			fill_q     <= '0;
			done_q     <= 1'b0;
			avg_end_q  <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			case (state_q)
				ccslm_pkg::ST_IDLE: begin
					if (in_xfer)
						item_ph_q <= mode_q;
				end
				ccslm_pkg::ST_EVAL: begin
					case (item_ph_q)
						ccslm_pkg::PH_CALIB: begin
							avg_end_q <= 1'b0;
							if (prog_inc >= target) begin
								progress_q <= '0;
								done_q     <= 1'b1;
							end else begin
								progress_q <= prog_inc;
								done_q     <= 1'b0;
							end
						end
						ccslm_pkg::PH_RUN: begin
							done_q    <= 1'b0;
							avg_end_q <= avg_end_c;
							fill_q    <= avg_end_c ? '0 : fill_inc;
						end
						default: begin
							done_q    <= 1'b0;
							avg_end_q <= 1'b0;
						end
					endcase
				end
				ccslm_pkg::ST_TALLY: begin
					div_cnt_q <= '0;
					if (item_ph_q == ccslm_pkg::PH_CALIB && done_q)
						mode_q <= ccslm_pkg::PH_RUN;
					else if (item_ph_q == ccslm_pkg::PH_RUN && stat.stop)
						mode_q <= ccslm_pkg::PH_STOP;
				end
				ccslm_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + DC_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int i = 0; i < NC; i++)
				sample_s1[i] <= in_sample[i];
		end
	end

	//------------------------------------------------------------------
	// Lanes and merge
	//------------------------------------------------------------------
	for (genvar g = 0; g < NC; g++) begin : g_lane
		ccslm_lane #(
			.MAX_AVG (MAX_AVG)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (lane_cmd),
			.ceiling (cfg_ceil_q),
			.n       (avg_n),
			.sample  (sample_s1[g]),
			.flag    (lane_flags[g]),
			.avg     (lane_avg[g])
		);
	end

	ccslm_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.tally      (state_q == ccslm_pkg::ST_TALLY),
		.flags      (lane_flags),
		.loss_limit (cfg_limit_q),
		.stat       (stat)
	);

	//------------------------------------------------------------------
	// Result register: holds a finished transfer while the next item is taken
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_phase_q <= mode_q;
			res_ctrl_q  <= (item_ph_q == ccslm_pkg::PH_CALIB) ||
			               (item_ph_q == ccslm_pkg::PH_RUN && avg_end_q);
			for (int i = 0; i < NC; i++) begin
				if (item_ph_q == ccslm_pkg::PH_CALIB)
					res_cur_q[i] <= sample_s1[i];
				else if (item_ph_q == ccslm_pkg::PH_RUN && avg_end_q)
					res_cur_q[i] <= lane_avg[i];
				else
					res_cur_q[i] <= '0;
			end
			res_flags_q <= lane_flags;
			res_total_q <= stat.total;
			res_done_q  <= done_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign phase      = res_phase_q;
	assign ctrl_valid = res_ctrl_q;
	assign cur_a1     = res_cur_q[0];
	assign cur_a2     = res_cur_q[1];
	assign cur_b1     = res_cur_q[2];
	assign cur_b2     = res_cur_q[3];
	assign loss_flags = res_flags_q;
	assign loss_total = res_total_q;
	assign calib_done = res_done_q;

endmodule

>>> hdl/ccslm_lane.sv
// One coil lane: rise detection, calibration maximum, running sum and serial divider.
module ccslm_lane #(
	parameter int  MAX_AVG = 32,
	localparam int N_W     = $clog2(MAX_AVG + 1),
	localparam int SUM_W   = ccslm_pkg::SAMPLE_BITS + $clog2(MAX_AVG)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ccslm_pkg::lane_cmd_t              cmd,
	input  logic [ccslm_pkg::SAMPLE_BITS-1:0] ceiling,
	input  logic [N_W-1:0]                    n,
	input  logic [ccslm_pkg::SAMPLE_BITS-1:0] sample,
	output logic                              flag,
	output logic [ccslm_pkg::SAMPLE_BITS-1:0] avg
);

	localparam int SB = ccslm_pkg::SAMPLE_BITS;
	localparam int MW = ccslm_pkg::MAX_W;
	localparam int PW = MW + ccslm_pkg::MARGIN_MUL_W;

	logic [SB-1:0]    prev_q;
	logic [MW-1:0]    max_q;
	logic [SUM_W-1:0] sum_q;
	logic             flag_q;
	logic [SUM_W-1:0] quo_q;
	logic [N_W-1:0]   rem_q;

	logic [SB-1:0]    rise;
	logic             hit;
	logic [SUM_W-1:0] sum_nxt;
	logic [PW-1:0]    prod;
	logic [N_W:0]     rem_sh;
	logic [N_W:0]     rem_sub;
	logic             rem_ge;

	always_comb begin
		rise    = sample - prev_q;
		hit     = (sample > prev_q) && (MW'(rise) > max_q) && (rise < ceiling);
		sum_nxt = sum_q + SUM_W'(sample);
		prod    = PW'(max_q) * PW'(ccslm_pkg::MARGIN_MUL);
		rem_sh  = {rem_q, quo_q[SUM_W-1]};
		rem_sub = rem_sh - {1'b0, n};
		rem_ge  = rem_sh >= {1'b0, n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			max_q  <= '0;
			sum_q  <= '0;
			flag_q <= 1'b0;
		end else if (cmd.eval) begin
			if (cmd.calib) begin
				if (hit)
					max_q <= MW'(rise);
				prev_q <= sample;
				flag_q <= 1'b0;
			end else if (cmd.run) begin
				sum_q  <= cmd.avg_end ? '0 : sum_nxt;
				flag_q <= cmd.detect & hit;
				if (cmd.detect)
					prev_q <= sample;
			end else begin
				flag_q <= 1'b0;
			end
		end else if (cmd.margin) begin
			max_q <= prod[ccslm_pkg::MARGIN_SHIFT +: MW];
		end
	end

	// restoring divide, one quotient bit per step, dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (cmd.eval && cmd.run && cmd.avg_end) begin
			quo_q <= sum_nxt;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], rem_ge};
		end
	end

	assign flag = flag_q;
	assign avg  = quo_q[SB-1:0];

endmodule

>>> hdl/ccslm_merge.sv
// Merges lane loss flags into the saturating event count and the stop decision.
module ccslm_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tally,
	input  logic [ccslm_pkg::NUM_COILS-1:0]   flags,
	input  logic [ccslm_pkg::LOSS_W-1:0]      loss_limit,
	output ccslm_pkg::merge_stat_t            stat
);

	localparam int LW = ccslm_pkg::LOSS_W;
	localparam int PW = ccslm_pkg::PC_W;

	logic [LW-1:0] events_q;
	logic [PW-1:0] hits;
	logic [LW:0]   sum;
	logic [LW-1:0] events_nxt;

	always_comb begin
		hits = '0;
		for (int i = 0; i < ccslm_pkg::NUM_COILS; i++)
			hits = hits + PW'(flags[i]);
		sum        = {1'b0, events_q} + (LW + 1)'(hits);
		events_nxt = sum[LW] ? '1 : sum[LW-1:0];
		// count only rises monotonically, so checking the final count matches per-event checks
		stat.stop  = (|flags) && (events_nxt > loss_limit);
		stat.total = events_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			events_q <= '0;
		else if (tally)
			events_q <= events_nxt;
	end

endmodule

>>> hdl/ccslm_checker.sv
// Port-level checks of the step-loss monitor and their binding to the top level.
module ccslm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [1:0]                        phase,
	input logic                              ctrl_valid,
	input logic [ccslm_pkg::SAMPLE_BITS-1:0] cur_a1,
	input logic [ccslm_pkg::SAMPLE_BITS-1:0] cur_a2,
	input logic [ccslm_pkg::SAMPLE_BITS-1:0] cur_b1,
	input logic [ccslm_pkg::SAMPLE_BITS-1:0] cur_b2,
	input logic [ccslm_pkg::NUM_COILS-1:0]   loss_flags,
	input logic [ccslm_pkg::LOSS_W-1:0]      loss_total,
	input logic                              calib_done
);

	// one item in flight: a transfer closes the input side for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(loss_total))
		else $error("stalled result changed");

	a_done_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calib_done |-> phase == ccslm_pkg::PH_RUN && loss_flags == '0 && ctrl_valid)
		else $error("end of calibration without entering run phase");

	a_zero_cur: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ctrl_valid |->
			cur_a1 == '0 && cur_a2 == '0 && cur_b1 == '0 && cur_b2 == '0)
		else $error("stale current shown without ctrl_valid");

	a_flags_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && loss_flags != '0 |-> loss_total != '0 && phase != ccslm_pkg::PH_CALIB)
		else $error("loss flagged without a counted event");

endmodule

bind coil_current_step_loss_monitor_core ccslm_checker u_ccslm_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for the coil current step-loss monitor: calibration, averaging, loss latch.
`timescale 1ns / 100ps

module tb_top;

	// ---------------------------------------------------------------------------------
	// Bench constants
	// ---------------------------------------------------------------------------------
	localparam int SB            = ccslm_pkg::SAMPLE_BITS;
	localparam int NC            = ccslm_pkg::NUM_COILS;
	localparam int LW            = ccslm_pkg::LOSS_W;
	localparam int AVG_CAP       = 32;                  // averaging depth cap of the block
	localparam int SMP_MAX       = (1 << SB) - 1;
	localparam int SETTLE_CYCLES = 32;                  // covers the longest (averaging) latency
	localparam int CYCLE_LIMIT   = 300000;              // far beyond the slowest legal run

	// Index past the end of the register map; writes there must be dropped.
	localparam logic [ccslm_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd5;

	// Coil order everywhere: 0 = A1, 1 = A2, 2 = B1, 3 = B2 (flag bit i = coil i).
	typedef logic [NC-1:0][SB-1:0] coil_set_t;

	typedef struct packed {
		ccslm_pkg::phase_t    phase;
		logic                 ctrl_valid;
		logic [NC-1:0][SB-1:0] cur;
		logic [NC-1:0]        flags;
		logic [LW-1:0]        total;
		logic                 done;
	} monitor_out_t;

	// ---------------------------------------------------------------------------------
	// DUT signals
	// ---------------------------------------------------------------------------------
	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	logic [SB-1:0]                    coil_a1_sample;
	logic [SB-1:0]                    coil_a2_sample;
	logic [SB-1:0]                    coil_b1_sample;
	logic [SB-1:0]                    coil_b2_sample;
	logic                             out_valid;
	logic                             out_ready;
	logic [1:0]                       phase;
	logic                             ctrl_valid;
	logic [SB-1:0]                    cur_a1;
	logic [SB-1:0]                    cur_a2;
	logic [SB-1:0]                    cur_b1;
	logic [SB-1:0]                    cur_b2;
	logic [NC-1:0]                    loss_flags;
	logic [LW-1:0]                    loss_total;
	logic                             calib_done;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [ccslm_pkg::ADDR_W-1:0]     paddr;
	logic [ccslm_pkg::DATA_W-1:0]     pwdata;
	logic [ccslm_pkg::DATA_W-1:0]     prdata;
	logic                             pready;

	coil_current_step_loss_monitor_core #(
		.MAX_AVG(AVG_CAP)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.coil_a1_sample(coil_a1_sample),
		.coil_a2_sample(coil_a2_sample),
		.coil_b1_sample(coil_b1_sample),
		.coil_b2_sample(coil_b2_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.phase         (phase),
		.ctrl_valid    (ctrl_valid),
		.cur_a1        (cur_a1),
		.cur_a2        (cur_a2),
		.cur_b1        (cur_b1),
		.cur_b2        (cur_b2),
		.loss_flags    (loss_flags),
		.loss_total    (loss_total),
		.calib_done    (calib_done),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// ---------------------------------------------------------------------------------
	// Shared bench state
	// ---------------------------------------------------------------------------------
	monitor_out_t pending_reports[$];  // expected results, oldest first
	int           fail_count    = 0;
	int           idle_pct      = 0;   // chance (percent) of an idle burst on either side
	int           stall_request = 0;   // cycles the result side must hold off, 0 = none
	int           cycle_count   = 0;

	// Mirror of the register file
	logic [ccslm_pkg::CALIB_W-1:0]  calib_cfg  = ccslm_pkg::RST_CALIB_SAMPLES;
	logic [ccslm_pkg::AVGCNT_W-1:0] avg_cfg    = ccslm_pkg::RST_AVG_COUNT;
	logic                           detect_cfg = ccslm_pkg::RST_DETECT_EN;
	logic [LW-1:0]                  limit_cfg  = ccslm_pkg::RST_LOSS_LIMIT;
	logic [SB-1:0]                  ceil_cfg   = ccslm_pkg::RST_DELTA_CEILING;

	// Mirror of the monitor state (reset values)
	logic [SB-1:0]                 last_smp [NC] = '{default: '0};
	int                            peak_rise[NC] = '{default: 0};
	int                            acc_sum  [NC] = '{default: 0};
	int                            fill_cnt   = 0;
	logic [ccslm_pkg::CALIB_W-1:0] calib_seen = '0;
	int                            loss_seen  = 0;
	ccslm_pkg::phase_t             mon_phase  = ccslm_pkg::PH_CALIB;

	// ---------------------------------------------------------------------------------
	// Clock, timeout
	// ---------------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("coil_current_step_loss_monitor_core regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Predictor: advances the mirrored state by one sample set, returns the result.
	// ---------------------------------------------------------------------------------
	function automatic monitor_out_t track_coils(coil_set_t s);
		monitor_out_t r;
		int           rise;
		int           n;
		int           target;
		r = '0;
		case (mon_phase)
		ccslm_pkg::PH_CALIB: begin
			// pass-through; track the largest rise that stays under the ceiling
			target = (calib_cfg == 0) ? 1 : int'(calib_cfg);
			for (int i = 0; i < NC; i++) begin
				rise = int'(s[i]) - int'(last_smp[i]);
				if (rise > 0 && rise > peak_rise[i] && rise < int'(ceil_cfg))
					peak_rise[i] = rise;
				last_smp[i] = s[i];
				r.cur[i]    = s[i];
			end
			r.ctrl_valid = 1'b1;
			calib_seen   = calib_seen + 1'b1;
			if (int'(calib_seen) >= target) begin
				// 10% margin, floor(max * 11 / 10)
				for (int i = 0; i < NC; i++)
					peak_rise[i] = peak_rise[i] * 11 / 10;
				calib_seen = '0;
				r.done     = 1'b1;
				mon_phase  = ccslm_pkg::PH_RUN;
			end
		end
		ccslm_pkg::PH_RUN: begin
			n = (avg_cfg == 0) ? 1 : (avg_cfg > AVG_CAP) ? AVG_CAP : int'(avg_cfg);
			for (int i = 0; i < NC; i++)
				acc_sum[i] += int'(s[i]);
			fill_cnt++;
			if (fill_cnt >= n) begin
				for (int i = 0; i < NC; i++) begin
					r.cur[i]   = SB'(acc_sum[i] / n);
					acc_sum[i] = 0;
				end
				fill_cnt     = 0;
				r.ctrl_valid = 1'b1;
			end
			// with detection off the previous sample is frozen
			if (detect_cfg) begin
				for (int i = 0; i < NC; i++) begin
					rise = int'(s[i]) - int'(last_smp[i]);
					if (rise > 0 && rise > peak_rise[i] && rise < int'(ceil_cfg)) begin
						r.flags[i] = 1'b1;
						if (loss_seen < 255)
							loss_seen++;
						if (loss_seen > int'(limit_cfg))
							mon_phase = ccslm_pkg::PH_STOP;
					end
					last_smp[i] = s[i];
				end
			end
		end
		default: begin
			// stopped: item ignored, nothing changes
		end
		endcase
		r.phase = mon_phase;
		r.total = LW'(loss_seen);
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------------

	// Sample set offset from the last tracked samples, clamped to the converter range.
	function automatic coil_set_t nudge(int da1, int da2, int db1, int db2);
		int        step[NC];
		int        v;
		coil_set_t s;
		step[0] = da1;
		step[1] = da2;
		step[2] = db1;
		step[3] = db2;
		for (int i = 0; i < NC; i++) begin
			v = int'(last_smp[i]) + step[i];
			if (v < 0)
				v = 0;
			if (v > SMP_MAX)
				v = SMP_MAX;
			s[i] = SB'(v);
		end
		return s;
	endfunction

	// Random walk step per coil in [-down, +up].
	function automatic coil_set_t drift(int up, int down);
		return nudge(int'($urandom_range(0, up + down)) - down,
			int'($urandom_range(0, up + down)) - down,
			int'($urandom_range(0, up + down)) - down,
			int'($urandom_range(0, up + down)) - down);
	endfunction

	function automatic coil_set_t noise();
		coil_set_t s;
		for (int i = 0; i < NC; i++)
			s[i] = SB'($urandom_range(0, SMP_MAX));
		return s;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// One sample transfer. Valid stays high after the transfer; the next call either
	// replaces the payload or drops valid for an idle burst.
	task automatic deliver(input coil_set_t s);
		int gap;
		gap = (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       = 1'b1;
		coil_a1_sample = s[0];
		coil_a2_sample = s[1];
		coil_b1_sample = s[2];
		coil_b2_sample = s[3];
		do @(posedge clk); while (!in_ready);
		pending_reports.push_back(track_coils(s));
	endtask

	// Stop offering samples and wait until the block has delivered everything.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic peek_reg(input logic [ccslm_pkg::REG_IDX_W-1:0] idx,
		output logic [ccslm_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Register write while the block is idle; upper bits carry junk to exercise masking.
	task automatic program_reg(input logic [ccslm_pkg::REG_IDX_W-1:0] idx,
		input int unsigned value);
		logic [ccslm_pkg::DATA_W-1:0] mask;
		logic [ccslm_pkg::DATA_W-1:0] word;
		logic [ccslm_pkg::DATA_W-1:0] got;
		drain();
		case (idx)
		ccslm_pkg::REG_CALIB_SAMPLES: mask = (1 << ccslm_pkg::CALIB_W) - 1;
		ccslm_pkg::REG_AVG_COUNT:     mask = (1 << ccslm_pkg::AVGCNT_W) - 1;
		ccslm_pkg::REG_DETECT_EN:     mask = 1;
		ccslm_pkg::REG_LOSS_LIMIT:    mask = (1 << LW) - 1;
		ccslm_pkg::REG_DELTA_CEILING: mask = (1 << SB) - 1;
		default:                      mask = '0;
		endcase
		word = (value & mask) | ($urandom & ~mask);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		ccslm_pkg::REG_CALIB_SAMPLES: calib_cfg  = word[ccslm_pkg::CALIB_W-1:0];
		ccslm_pkg::REG_AVG_COUNT:     avg_cfg    = word[ccslm_pkg::AVGCNT_W-1:0];
		ccslm_pkg::REG_DETECT_EN:     detect_cfg = word[0];
		ccslm_pkg::REG_LOSS_LIMIT:    limit_cfg  = word[LW-1:0];
		ccslm_pkg::REG_DELTA_CEILING: ceil_cfg   = word[SB-1:0];
		default:                      ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (mask != 0) begin
			peek_reg(idx, got);
			check_field($sformatf("register %0d readback", idx), word & mask, got);
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Result side: random stalls, plus one long hold-off on request (fills the block)
	// ---------------------------------------------------------------------------------
	initial begin : result_sink
		int span;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request > 0) begin
				span          = stall_request;
				stall_request = 0;
				out_ready     = 1'b0;
				repeat (span - 1) @(negedge clk);
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				span      = $urandom_range(1, 10);
				out_ready = 1'b0;
				repeat (span - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Result check: every transfer on the result side against the oldest expectation
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin : report_check
		monitor_out_t          want;
		coil_set_t             got_cur;
		string                 coil_tag[NC];
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result transfer with no sample pending");
				fail_count++;
			end else begin
				want        = pending_reports.pop_front();
				got_cur     = {cur_b2, cur_b1, cur_a2, cur_a1};
				coil_tag    = '{"cur_a1", "cur_a2", "cur_b1", "cur_b2"};
				check_field("phase", want.phase, phase);
				check_field("ctrl_valid", want.ctrl_valid, ctrl_valid);
				for (int i = 0; i < NC; i++)
					check_field(coil_tag[i], want.cur[i], got_cur[i]);
				check_field("loss_flags", want.flags, loss_flags);
				check_field("loss_total", want.total, loss_total);
				check_field("calib_done", want.done, calib_done);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------

	task automatic test_register_defaults();
		logic [ccslm_pkg::DATA_W-1:0] got;
		peek_reg(ccslm_pkg::REG_CALIB_SAMPLES, got);
		check_field("calib_samples reset", ccslm_pkg::RST_CALIB_SAMPLES, got);
		peek_reg(ccslm_pkg::REG_AVG_COUNT, got);
		check_field("avg_count reset", ccslm_pkg::RST_AVG_COUNT, got);
		peek_reg(ccslm_pkg::REG_DETECT_EN, got);
		check_field("loss_detect_enable reset", ccslm_pkg::RST_DETECT_EN, got);
		peek_reg(ccslm_pkg::REG_LOSS_LIMIT, got);
		check_field("loss_limit reset", ccslm_pkg::RST_LOSS_LIMIT, got);
		peek_reg(ccslm_pkg::REG_DELTA_CEILING, got);
		check_field("delta_ceiling reset", ccslm_pkg::RST_DELTA_CEILING, got);
	endtask

	// Pass-through and peak tracking, ceiling at its edges, junk register index.
	task automatic test_calibration_passthrough();
		idle_pct = 20;
		program_reg(ccslm_pkg::REG_LOSS_LIMIT, 255);      // saturated count never exceeds it
		program_reg(ccslm_pkg::REG_CALIB_SAMPLES, 16383);
		program_reg(ccslm_pkg::REG_AVG_COUNT, 1);
		program_reg(REG_SPARE, 7);                        // must be dropped
		program_reg(ccslm_pkg::REG_DELTA_CEILING, 300);
		deliver('0);                            // unchanged from reset: no rise
		deliver({4{12'd300}});                  // rise equal to the ceiling: ignored
		deliver(nudge(299, 150, 100, 50));      // largest rise just under the ceiling
		deliver({4{12'hFFF}});
		deliver('0);                            // fall
		program_reg(ccslm_pkg::REG_DELTA_CEILING, 0);     // nothing counts as a rise
		deliver(nudge(200, 200, 200, 200));
		deliver({12'hFFF, 12'd0, 12'hFFF, 12'd0});
		program_reg(ccslm_pkg::REG_DELTA_CEILING, 4000);
	endtask

	// Ends calibration with a zero target (treated as one) after a near miss.
	task automatic test_calibration_end();
		repeat (20) deliver(drift(250, 250));
		program_reg(ccslm_pkg::REG_CALIB_SAMPLES, int'(calib_seen) + 3);
		repeat (2) deliver(drift(250, 250));    // one short of the target
		program_reg(ccslm_pkg::REG_CALIB_SAMPLES, 0);
		deliver(drift(250, 250));               // calib_done, margin applied
	endtask

	// Threshold edges, ceiling extremes, detection gating with frozen history.
	task automatic test_loss_detection();
		program_reg(ccslm_pkg::REG_DELTA_CEILING, 4095);
		deliver({4{12'd1000}});
		deliver(nudge(peak_rise[0], peak_rise[1], peak_rise[2], peak_rise[3]));
		deliver(nudge(peak_rise[0] + 1, peak_rise[1] + 1, peak_rise[2] + 1,
			peak_rise[3] + 1));
		deliver(nudge(-100, -100, -100, -100));
		deliver('0);
		// B2, B1, A2, A1: full-scale rise sits on the ceiling, one below counts
		deliver({12'd4094, 12'hFFF, 12'd0, 12'd4094});
		program_reg(ccslm_pkg::REG_DETECT_EN, 0);
		deliver({4{12'd2000}});
		deliver({4{12'hFFF}});
		program_reg(ccslm_pkg::REG_DETECT_EN, 1);
		// history still holds the samples from before detection was switched off
		deliver(nudge(1, peak_rise[1] + 1, 0, -5));
	endtask

	// Depth clamping and a depth lowered below the current fill.
	task automatic test_averaging();
		program_reg(ccslm_pkg::REG_AVG_COUNT, 0);         // acts as one
		deliver(drift(100, 100));
		program_reg(ccslm_pkg::REG_AVG_COUNT, 32);
		repeat (6) deliver(drift(100, 100));
		program_reg(ccslm_pkg::REG_AVG_COUNT, 3);         // next sample closes the average
		deliver(drift(100, 100));
	endtask

	// Random walks with spikes, full-range noise and repeats under changing settings.
	task automatic test_random_traffic();
		int pick;
		for (int seg = 0; seg < 10; seg++) begin
			idle_pct = (seg % 3 == 0) ? 0 : (seg % 3 == 1) ? 15 : 40;
			program_reg(ccslm_pkg::REG_AVG_COUNT, (seg == 0) ? 63 : (seg == 1) ? 1 :
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8));
			program_reg(ccslm_pkg::REG_DETECT_EN,
				(seg == 2) ? 0 : ($urandom_range(0, 3) != 0));
			program_reg(ccslm_pkg::REG_DELTA_CEILING,
				$urandom_range(0, 1) ? 4095 : $urandom_range(0, SMP_MAX));
			program_reg(ccslm_pkg::REG_CALIB_SAMPLES, $urandom_range(0, 16383));
			if (seg == 4)
				stall_request = 400;            // long hold-off while samples keep coming
			repeat (50) begin
				pick = $urandom_range(0, 19);
				if (pick < 12)
					deliver(drift(400, 300));
				else if (pick < 14)
					deliver(drift(2500, 0));
				else if (pick < 18)
					deliver(noise());
				else
					deliver(nudge(0, 0, 0, 0));
			end
		end
	endtask

	// Lowest limit: the next loss event latches the stop; later samples are ignored.
	task automatic test_stop_latch();
		idle_pct = 0;
		program_reg(ccslm_pkg::REG_DELTA_CEILING, 4095);
		program_reg(ccslm_pkg::REG_DETECT_EN, 1);
		program_reg(ccslm_pkg::REG_AVG_COUNT, 2);
		program_reg(ccslm_pkg::REG_LOSS_LIMIT, 0);
		deliver('0);
		deliver(nudge(-50, -50, -50, -50));
		deliver(nudge(peak_rise[0] + 1, peak_rise[1] + 1, peak_rise[2] + 1,
			peak_rise[3] + 1));
		repeat (4) deliver(noise());
	endtask

	// ---------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		coil_a1_sample = '0;
		coil_a2_sample = '0;
		coil_b1_sample = '0;
		coil_b2_sample = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_defaults();
		test_calibration_passthrough();
		test_calibration_end();
		test_loss_detection();
		test_averaging();
		test_random_traffic();
		test_stop_latch();
		drain();

		if (fail_count == 0) begin
			$display("coil_current_step_loss_monitor_core regression: pass");
		end else begin
			$display("coil_current_step_loss_monitor_core regression: fail");
		end
		$finish;
	end

endmodule
